// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/pva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  localparam logic [1:0] OP_ALLOCATE    = 2'd0;
  localparam logic [1:0] OP_RELEASE     = 2'd1;
  localparam logic [1:0] OP_RELEASE_ALL = 2'd2;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned SLOT_W = 7;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch request, reset scan state
    logic scan;    // walk the voice table
    logic clear;   // free one entry per cycle
    logic commit;  // write back the outcome of the request
    logic load;    // load the output register
  } pva_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic clr_last;
  } pva_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pva_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pva_datapath #(
  parameter int unsigned VOICES = 128
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pva_pkg::pva_cmd_t                   cmd_i,
  output      pva_pkg::pva_status_t                status_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic [pva_pkg::PRIO_W-1:0]          req_priority_i,
  input  wire logic [pva_pkg::SLOT_W-1:0]          release_slot_i,
  output      logic                                granted_o,
  output      logic [pva_pkg::SLOT_W-1:0]          slot_o,
  output      logic                                evicted_o
);

  localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = ((IW > pva_pkg::SLOT_W) ? IW : pva_pkg::SLOT_W) + 1;
  localparam int unsigned EW = pva_pkg::PRIO_W + 1;   // {active, priority}
  localparam logic [IW:0] NumVoices = (IW + 1)'(VOICES);
  localparam logic [IW:0] LastCnt   = (IW + 1)'(VOICES - 1);
  localparam logic [IW-1:0] LastIdx = IW'(VOICES - 1);

  logic [EW-1:0]               voice_mem_q [VOICES];
  logic [EW-1:0]               rdata_q;
  logic                        rvalid_q;
  logic [IW-1:0]               ridx_q;
  logic [IW:0]                 cnt_q, cnt_d;

  logic [1:0]                  op_q;
  logic [pva_pkg::PRIO_W-1:0]  prio_q;
  logic [pva_pkg::SLOT_W-1:0]  rel_q;

  logic                        free_q, free_d;
  logic                        vict_q, vict_d;
  logic [IW-1:0]               free_idx_q, free_idx_d;
  logic [IW-1:0]               vict_idx_q, vict_idx_d;
  logic [pva_pkg::PRIO_W-1:0]  vict_prio_q, vict_prio_d;

  logic                        rd_en;
  logic                        we;
  logic [IW-1:0]               waddr;
  logic [EW-1:0]               wdata;
  logic                        hit;
  logic [IW-1:0]               tgt;
  logic [CW-1:0]               rel_ext;
  logic [CW-1:0]               tgt_ext;
  logic                        rel_ok;
  logic                        is_alloc;
  logic                        entry_act;
  logic [pva_pkg::PRIO_W-1:0]  entry_prio;

  assign rd_en      = cmd_i.scan && (cnt_q < NumVoices);
  assign entry_act  = rdata_q[EW-1];
  assign entry_prio = rdata_q[pva_pkg::PRIO_W-1:0];
  assign is_alloc   = (op_q == pva_pkg::OP_ALLOCATE);
  assign hit        = free_q || vict_q;
  assign tgt        = free_q ? free_idx_q : vict_idx_q;
  assign rel_ext    = CW'(rel_q);
  assign rel_ok     = (rel_ext < CW'(VOICES));
  assign tgt_ext    = CW'(tgt);

  assign status_o.scan_done = rvalid_q && (!entry_act || (ridx_q == LastIdx));
  assign status_o.clr_last  = (cnt_q == LastCnt);

  // counter: clear sweep and scan read address share it
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.clear || rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // running search: first free voice, else lowest-priority eligible victim
  always_comb begin
    free_d      = free_q;
    vict_d      = vict_q;
    free_idx_d  = free_idx_q;
    vict_idx_d  = vict_idx_q;
    vict_prio_d = vict_prio_q;
    if (cmd_i.start) begin
      free_d = 1'b0;
      vict_d = 1'b0;
    end else if (cmd_i.scan && rvalid_q && !free_q) begin
      if (!entry_act) begin
        free_d     = 1'b1;
        free_idx_d = ridx_q;
      end else if ((entry_prio <= prio_q) && (!vict_q || (entry_prio < vict_prio_q))) begin
        vict_d      = 1'b1;
        vict_idx_d  = ridx_q;
        vict_prio_d = entry_prio;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[IW-1:0];
    wdata = '0;
    if (cmd_i.clear) begin
      we = 1'b1;
    end else if (cmd_i.commit) begin
      if (is_alloc && hit) begin
        we    = 1'b1;
        waddr = tgt;
        wdata = {1'b1, prio_q};
      end else if ((op_q == pva_pkg::OP_RELEASE) && rel_ok) begin
        we    = 1'b1;
        waddr = rel_ext[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      voice_mem_q[waddr] <= wdata;
    end
    rdata_q <= voice_mem_q[cnt_q[IW-1:0]];
    ridx_q  <= cnt_q[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      free_q   <= 1'b0;
      vict_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rvalid_q <= rd_en;
      free_q   <= free_d;
      vict_q   <= vict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q  <= free_idx_d;
    vict_idx_q  <= vict_idx_d;
    vict_prio_q <= vict_prio_d;
    if (cmd_i.start) begin
      op_q   <= op_i;
      prio_q <= req_priority_i;
      rel_q  <= release_slot_i;
    end
    if (cmd_i.load) begin
      granted_o <= is_alloc && hit;
      slot_o    <= (is_alloc && hit) ? tgt_ext[pva_pkg::SLOT_W-1:0] : '0;
      evicted_o <= is_alloc && hit && !free_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pva_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [1:0]           op_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      pva_pkg::pva_cmd_t    cmd_o,
  input  wire pva_pkg::pva_status_t status_i
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_CLEAR  = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_FINISH = 6'b100000
  } pva_state_e;

  pva_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (op_i == pva_pkg::OP_ALLOCATE) begin
            state_d = ST_SCAN;
          end else if (op_i == pva_pkg::OP_RELEASE_ALL) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_voice_allocator.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------
// request  | in_valid_i / in_ready_o   | op_i, req_priority_i, release_slot_i
// result   | out_valid_o / out_ready_i | granted_o, slot_o, evicted_o
//
// Allocate: the scan reads one table entry per cycle from the voice memory,
//   stopping early at the first free voice. Release and the unused op skip
//   the scan, and release-all clears every entry of the table instead.
// After reset a clearing pass over every voice runs before the first request.
// A finished result waits in the output register; a further request is accepted
//   meanwhile and completes once that register has been emptied.
`timescale 1ns / 1ps
`default_nettype none

module priority_voice_allocator #(
  parameter int unsigned VOICES = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic [pva_pkg::PRIO_W-1:0] req_priority_i,
  input  wire logic [pva_pkg::SLOT_W-1:0] release_slot_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic                       granted_o,
  output      logic [pva_pkg::SLOT_W-1:0] slot_o,
  output      logic                       evicted_o
);

  pva_pkg::pva_cmd_t    cmd;
  pva_pkg::pva_status_t status;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pva_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .req_priority_i (req_priority_i),
    .release_slot_i (release_slot_i),
    .granted_o      (granted_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pva_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pva_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic                       granted_o,
  input wire logic [pva_pkg::SLOT_W-1:0] slot_o,
  input wire logic                       evicted_o
);

  `PVA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `PVA_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while busy")
  `PVA_ASSERT(a_refused_zero, out_valid_o && !granted_o |-> (slot_o == '0) && !evicted_o, "non-grant result carries slot or eviction")
  `PVA_ASSERT_ALWAYS(a_evict_granted, !rst_ni || !out_valid_o || !evicted_o || granted_o, "eviction without grant")

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (.*);

`default_nettype wire
